FILE: rtl/core/aopq_pkg.sv
`default_nettype none
// ============================================================================
// aopq_pkg
// Shared types, codes and constants of the age ordered priority queue.
// ============================================================================
package aopq_pkg;

    localparam int KEY_W   = 22;
    localparam int TAG_W   = 16;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int DIV25_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_DAY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_MONTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TODAY_YEAR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_ASC   = 2'd3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [DAY_W-1:0]   TODAY_DAY_RST   = 5'd1;
    localparam logic [MONTH_W-1:0] TODAY_MONTH_RST = 4'd1;
    localparam logic [YEAR_W-1:0]  TODAY_YEAR_RST  = 12'd2000;
    localparam logic               ORDER_ASC_RST   = 1'b1;

    // year / 25 as (year * 1311) >> 15, exact for any 12-bit year
    localparam int DIV25_MUL   = 1311;
    localparam int DIV25_SHIFT = 15;
    localparam int DIV25_PROD_W = YEAR_W + 11;
    localparam logic [DIV25_W-1:0] DIV25_RST = DIV25_W'(2000 / 25);

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;

    localparam logic signed [KEY_W-1:0] KEY_YEAR_MUL  = 22'sd365;
    localparam logic signed [KEY_W-1:0] KEY_MONTH_MUL = 22'sd30;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [DAY_W-1:0]        day;
        logic [MONTH_W-1:0]      month;
        logic [YEAR_W-1:0]       year;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    typedef struct packed {
        logic     compare;
        logic     asc;
        cell_op_t op;
    } cell_ctrl_t;

    typedef struct packed {
        logic compare;
        logic asc;
        logic insert;
        logic pop;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_KEY,
        PH_CMP,
        PH_UPD
    } phase_t;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd2:                   d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                d = 5'd31;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/aopq_keygen.sv
`default_nettype none
// ============================================================================
// aopq_keygen
// Age key from birth date against the current date, with month borrow.
// ============================================================================
module aopq_keygen
(
    input  wire logic [aopq_pkg::DAY_W-1:0]   today_day,
    input  wire logic [aopq_pkg::MONTH_W-1:0] today_month,
    input  wire logic [aopq_pkg::YEAR_W-1:0]  today_year,
    input  wire logic [aopq_pkg::DIV25_W-1:0] year_div25,
    input  wire logic [aopq_pkg::DAY_W-1:0]   birth_day,
    input  wire logic [aopq_pkg::MONTH_W-1:0] birth_month,
    input  wire logic [aopq_pkg::YEAR_W-1:0]  birth_year,
    output logic signed [aopq_pkg::KEY_W-1:0] key
);

    logic [aopq_pkg::YEAR_W-1:0]  q_ext;
    logic [aopq_pkg::YEAR_W-1:0]  rem25;
    logic                         leap;
    logic [aopq_pkg::MONTH_W-1:0] borrow_month;
    logic [aopq_pkg::DAY_W-1:0]   mlen;
    logic signed [12:0]           years_d;
    logic signed [12:0]           years_a;
    logic signed [6:0]            months_d;
    logic signed [6:0]            months_b;
    logic signed [6:0]            months_a;
    logic signed [6:0]            days_d;
    logic signed [6:0]            days_a;
    logic signed [aopq_pkg::KEY_W-1:0] y_ext;
    logic signed [aopq_pkg::KEY_W-1:0] m_ext;
    logic signed [aopq_pkg::KEY_W-1:0] d_ext;

    always_comb
    begin
        q_ext = {{(aopq_pkg::YEAR_W-aopq_pkg::DIV25_W){1'b0}}, year_div25};
        rem25 = today_year - (q_ext * 12'd25);
        leap  = (today_year[1:0] == 2'd0) && ((rem25 != '0) || (today_year[3:0] == 4'd0));

        borrow_month = (today_month == aopq_pkg::MONTH_JAN) ? aopq_pkg::MONTH_DEC
                                                            : (today_month - 4'd1);
        mlen = aopq_pkg::month_days(borrow_month);
        if ((borrow_month == aopq_pkg::MONTH_FEB) && leap)
        begin
            mlen = aopq_pkg::FEB_LEAP_DAYS;
        end

        years_d  = $signed({1'b0, today_year}) - $signed({1'b0, birth_year});
        months_d = $signed({3'b0, today_month}) - $signed({3'b0, birth_month});
        days_d   = $signed({2'b0, today_day}) - $signed({2'b0, birth_day});

        if (days_d < 7'sd0)
        begin
            days_a   = days_d + $signed({2'b0, mlen});
            months_b = months_d - 7'sd1;
        end
        else
        begin
            days_a   = days_d;
            months_b = months_d;
        end

        if (months_b < 7'sd0)
        begin
            months_a = months_b + 7'sd12;
            years_a  = years_d - 13'sd1;
        end
        else
        begin
            months_a = months_b;
            years_a  = years_d;
        end

        y_ext = {{(aopq_pkg::KEY_W-13){years_a[12]}}, years_a};
        m_ext = {{(aopq_pkg::KEY_W-7){months_a[6]}}, months_a};
        d_ext = {{(aopq_pkg::KEY_W-7){days_a[6]}}, days_a};
        key   = (y_ext * aopq_pkg::KEY_YEAR_MUL) + (m_ext * aopq_pkg::KEY_MONTH_MUL) + d_ext;
    end

endmodule
`default_nettype wire

FILE: rtl/core/aopq_cell.sv
`default_nettype none
// ============================================================================
// aopq_cell
// One queue slot: holds an entry, compares it with the incoming key and
// loads from the new entry or a neighbor.
// ============================================================================
module aopq_cell
(
    input  wire logic                clk,
    input  wire aopq_pkg::cell_ctrl_t ctrl,
    input  wire logic                live,
    input  wire aopq_pkg::entry_t    new_entry,
    input  wire aopq_pkg::entry_t    left_entry,
    input  wire aopq_pkg::entry_t    right_entry,
    output aopq_pkg::entry_t         entry,
    output logic                     beat
);

    aopq_pkg::entry_t entry_reg;
    aopq_pkg::entry_t entry_next;
    logic             beat_reg;
    logic             beat_next;
    logic             wins;

    always_comb
    begin
        if (ctrl.asc)
        begin
            wins = $signed(new_entry.key) < $signed(entry_reg.key);
        end
        else
        begin
            wins = $signed(new_entry.key) > $signed(entry_reg.key);
        end
        // an empty slot always takes the insert position
        beat_next = ctrl.compare ? (!live || wins) : beat_reg;
    end

    always_comb
    begin
        case (ctrl.op)
            aopq_pkg::CELL_LOAD:       entry_next = new_entry;
            aopq_pkg::CELL_FROM_LEFT:  entry_next = left_entry;
            aopq_pkg::CELL_FROM_RIGHT: entry_next = right_entry;
            default:                   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        beat_reg  <= beat_next;
    end

    assign entry = entry_reg;
    assign beat  = beat_reg;

endmodule
`default_nettype wire

FILE: rtl/core/aopq_chain.sv
`default_nettype none
// ============================================================================
// aopq_chain
// Row of queue cells with insert-position prefix and shift control.
// ============================================================================
module aopq_chain
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire aopq_pkg::chain_ctrl_t ctrl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
    input  wire aopq_pkg::entry_t      new_entry,
    output aopq_pkg::entry_t           front
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL   = $clog2(QUEUE_DEPTH);

    aopq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
    aopq_pkg::cell_ctrl_t cell_ctrl  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] beat;
    logic [QUEUE_DEPTH-1:0] live;
    logic [QUEUE_DEPTH-1:0] incl;
    logic [QUEUE_DEPTH-1:0] excl;

    // inclusive prefix OR: slot at or past the insert position
    always_comb
    begin
        incl = beat;
        for (int l = 0; l < LVL; l++)
        begin
            incl = incl | (incl << (1 << l));
        end
        excl = incl << 1;
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        aopq_pkg::entry_t left_e;
        aopq_pkg::entry_t right_e;

        assign live[g] = count > CNT_W'(g);

        if (g == 0)
        begin : g_first
            assign left_e = new_entry;
        end
        else
        begin : g_mid_l
            assign left_e = cell_entry[g-1];
        end

        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cell_entry[g];
        end
        else
        begin : g_mid_r
            assign right_e = cell_entry[g+1];
        end

        always_comb
        begin
            cell_ctrl[g].compare = ctrl.compare;
            cell_ctrl[g].asc     = ctrl.asc;
            if (ctrl.insert && excl[g])
            begin
                cell_ctrl[g].op = aopq_pkg::CELL_FROM_LEFT;
            end
            else if (ctrl.insert && incl[g])
            begin
                cell_ctrl[g].op = aopq_pkg::CELL_LOAD;
            end
            else if (ctrl.pop)
            begin
                cell_ctrl[g].op = aopq_pkg::CELL_FROM_RIGHT;
            end
            else
            begin
                cell_ctrl[g].op = aopq_pkg::CELL_HOLD;
            end
        end

        aopq_cell u_cell
        (
            .clk         (clk),
            .ctrl        (cell_ctrl[g]),
            .live        (live[g]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[g]),
            .beat        (beat[g])
        );
    end

    assign front = cell_entry[0];

endmodule
`default_nettype wire

FILE: rtl/core/age_ordered_priority_queue_top.sv
`default_nettype none
// ============================================================================
// age_ordered_priority_queue_top
// Bounded queue sorted by age key; insert and pop commands, one result each.
//
//   channel  | signals                                        | transfer
//   ---------+------------------------------------------------+---------------------
//   command  | start, busy, cmd, birth_*, entry_tag           | start & !busy
//   result   | done, status, out_*, occupancy                 | done, one cycle
//   config   | cfg_we, cfg_index, cfg_data                    | cfg_we
//
// An item runs key compute, parallel compare in every cell, prefix and
// shift of the cell row, then the result strobe; busy is high until the
// strobe. Results cannot be held off. Reset clears the count, phase and done
// and loads configuration defaults; cell contents stay undefined until written.
// ============================================================================
module age_ordered_priority_queue_top
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [aopq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [aopq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           cmd,
    input  wire logic [aopq_pkg::DAY_W-1:0]     birth_day,
    input  wire logic [aopq_pkg::MONTH_W-1:0]   birth_month,
    input  wire logic [aopq_pkg::YEAR_W-1:0]    birth_year,
    input  wire logic [aopq_pkg::TAG_W-1:0]     entry_tag,
    output logic                                done,
    output logic [aopq_pkg::STAT_W-1:0]         status,
    output logic [aopq_pkg::TAG_W-1:0]          out_tag,
    output logic [aopq_pkg::DAY_W-1:0]          out_day,
    output logic [aopq_pkg::MONTH_W-1:0]        out_month,
    output logic [aopq_pkg::YEAR_W-1:0]         out_year,
    output logic [aopq_pkg::OCC_W-1:0]          occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [aopq_pkg::DAY_W-1:0]   today_day_reg;
    logic [aopq_pkg::MONTH_W-1:0] today_month_reg;
    logic [aopq_pkg::YEAR_W-1:0]  today_year_reg;
    logic [aopq_pkg::DIV25_W-1:0] year_div25_reg;
    logic                         order_asc_reg;
    logic [aopq_pkg::DIV25_PROD_W-1:0] div25_prod;

    aopq_pkg::phase_t phase_reg;
    aopq_pkg::phase_t phase_next;

    logic                         cmd_reg;
    logic [aopq_pkg::DAY_W-1:0]   day_reg;
    logic [aopq_pkg::MONTH_W-1:0] month_reg;
    logic [aopq_pkg::YEAR_W-1:0]  year_reg;
    logic [aopq_pkg::TAG_W-1:0]   tag_reg;
    logic signed [aopq_pkg::KEY_W-1:0] key_reg;
    logic signed [aopq_pkg::KEY_W-1:0] key_comb;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             full;
    logic             empty;

    logic                         done_reg;
    logic                         done_next;
    logic [aopq_pkg::STAT_W-1:0]  status_reg;
    logic [aopq_pkg::STAT_W-1:0]  status_next;
    aopq_pkg::entry_t             out_reg;
    aopq_pkg::entry_t             out_next;

    aopq_pkg::chain_ctrl_t chain_ctrl;
    aopq_pkg::entry_t      new_entry;
    aopq_pkg::entry_t      front;
    logic                  accept;

    assign accept = start && (phase_reg == aopq_pkg::PH_IDLE);
    assign full   = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty  = count_reg == '0;

    // configuration
    assign div25_prod = aopq_pkg::DIV25_PROD_W'(cfg_data) * aopq_pkg::DIV25_PROD_W'(aopq_pkg::DIV25_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            today_day_reg   <= aopq_pkg::TODAY_DAY_RST;
            today_month_reg <= aopq_pkg::TODAY_MONTH_RST;
            today_year_reg  <= aopq_pkg::TODAY_YEAR_RST;
            year_div25_reg  <= aopq_pkg::DIV25_RST;
            order_asc_reg   <= aopq_pkg::ORDER_ASC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                aopq_pkg::CFG_TODAY_DAY:   today_day_reg   <= cfg_data[aopq_pkg::DAY_W-1:0];
                aopq_pkg::CFG_TODAY_MONTH: today_month_reg <= cfg_data[aopq_pkg::MONTH_W-1:0];
                aopq_pkg::CFG_TODAY_YEAR:
                begin
                    today_year_reg <= cfg_data[aopq_pkg::YEAR_W-1:0];
                    year_div25_reg <= div25_prod[aopq_pkg::DIV25_SHIFT +: aopq_pkg::DIV25_W];
                end
                aopq_pkg::CFG_ORDER_ASC:   order_asc_reg   <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // phase sequencing
    always_comb
    begin
        case (phase_reg)
            aopq_pkg::PH_IDLE: phase_next = accept ? aopq_pkg::PH_KEY : aopq_pkg::PH_IDLE;
            aopq_pkg::PH_KEY:  phase_next = aopq_pkg::PH_CMP;
            aopq_pkg::PH_CMP:  phase_next = aopq_pkg::PH_UPD;
            aopq_pkg::PH_UPD:  phase_next = aopq_pkg::PH_IDLE;
            default:           phase_next = aopq_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        chain_ctrl.compare = phase_reg == aopq_pkg::PH_CMP;
        chain_ctrl.asc     = order_asc_reg;
        chain_ctrl.insert  = (phase_reg == aopq_pkg::PH_UPD) && (cmd_reg == aopq_pkg::CMD_INSERT)
                             && !full;
        chain_ctrl.pop     = (phase_reg == aopq_pkg::PH_UPD) && (cmd_reg == aopq_pkg::CMD_POP)
                             && !empty;
        busy               = phase_reg != aopq_pkg::PH_IDLE;
    end

    always_comb
    begin
        count_next  = count_reg;
        done_next   = phase_reg == aopq_pkg::PH_UPD;
        status_next = status_reg;
        out_next    = out_reg;
        if (phase_reg == aopq_pkg::PH_UPD)
        begin
            status_next = aopq_pkg::STATUS_OK;
            out_next    = '0;
            if (cmd_reg == aopq_pkg::CMD_INSERT)
            begin
                if (full)
                begin
                    status_next = aopq_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = aopq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    out_next   = front;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aopq_pkg::PH_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        out_reg    <= out_next;
        if (accept)
        begin
            cmd_reg   <= cmd;
            day_reg   <= birth_day;
            month_reg <= birth_month;
            year_reg  <= birth_year;
            tag_reg   <= entry_tag;
        end
        if (phase_reg == aopq_pkg::PH_KEY)
        begin
            key_reg <= key_comb;
        end
    end

    aopq_keygen u_keygen
    (
        .today_day   (today_day_reg),
        .today_month (today_month_reg),
        .today_year  (today_year_reg),
        .year_div25  (year_div25_reg),
        .birth_day   (day_reg),
        .birth_month (month_reg),
        .birth_year  (year_reg),
        .key         (key_comb)
    );

    always_comb
    begin
        new_entry.key   = key_reg;
        new_entry.tag   = tag_reg;
        new_entry.day   = day_reg;
        new_entry.month = month_reg;
        new_entry.year  = year_reg;
    end

    aopq_chain #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_chain
    (
        .clk       (clk),
        .ctrl      (chain_ctrl),
        .count     (count_reg),
        .new_entry (new_entry),
        .front     (front)
    );

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_tag   = out_reg.tag;
    assign out_day   = out_reg.day;
    assign out_month = out_reg.month;
    assign out_year  = out_reg.year;
    assign occupancy = aopq_pkg::OCC_W'(count_reg);

endmodule
`default_nettype wire
